[rtl/divisor_count_macros.svh]
// assertion macros used by the checker file
`ifndef DIVISOR_COUNT_MACROS_SVH
`define DIVISOR_COUNT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divisor_count check failed");

// next-cycle implication, disabled while in reset
`define DC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divisor_count check failed");

`endif

[rtl/dc_pkg.sv]
// shared types and constants of the divisor count block
package dc_pkg;

    localparam int VALUE_IN_W = 32;
    localparam int EXT_W      = 64;
    localparam int TOTAL_W    = 11;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;
    localparam int FIRST_PRIME = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIV,
        ST_DECIDE,
        ST_FINISH
    } dc_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic take_quotient;
        logic next_prime;
        logic finish;
    } dc_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic div_busy;
        logic rem_zero;
        logic exp_zero;
        logic n_gt1;
        logic p_le_q;
    } dc_status_t;

endpackage

[rtl/dc_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
module dc_divider #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;

    logic [W:0]   rem_shift;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, divisor};
        fits      = !diff[W];
        rem_next  = fits ? diff[W-1:0] : rem_shift[W-1:0];
        quo_next  = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(W - 1);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/dc_datapath.sv]
// working value, trial divisor, exponent and running product
module dc_datapath #(
    parameter int W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dc_pkg::VALUE_IN_W-1:0] value_in,
    input  dc_pkg::dc_cmd_t              cmd,
    output dc_pkg::dc_status_t           status,
    output logic [dc_pkg::TOTAL_W-1:0]   divisor_total,
    output logic                         done
);

    localparam int EXP_W = $clog2(W + 2);
    localparam int MUL_W = dc_pkg::TOTAL_W + EXP_W;

    logic [W-1:0]                n_reg;
    logic [W-1:0]                p_reg;
    logic [EXP_W-1:0]            exp_reg;
    logic [dc_pkg::TOTAL_W-1:0]  prod_reg;
    logic [dc_pkg::TOTAL_W-1:0]  total_reg;
    logic                        done_reg;

    logic [dc_pkg::EXT_W-1:0]    value_ext;
    logic                        div_busy;
    logic [W-1:0]                quotient;
    logic [W-1:0]                remainder;
    logic [EXP_W-1:0]            factor;
    logic [MUL_W-1:0]            mul_full;
    logic [dc_pkg::TOTAL_W-1:0]  prod_next;
    logic [dc_pkg::TOTAL_W-1:0]  doubled;
    logic [dc_pkg::TOTAL_W-1:0]  total_next;

    dc_divider #(
        .W (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (p_reg),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        value_ext = {{(dc_pkg::EXT_W - dc_pkg::VALUE_IN_W){1'b0}}, value_in};
        factor    = exp_reg + 1'b1;
        mul_full  = MUL_W'(prod_reg) * MUL_W'(factor);
        // saturating product, exact since every factor is at least one
        prod_next = (mul_full > MUL_W'(dc_pkg::TOTAL_MAX)) ? dc_pkg::TOTAL_MAX
                                                           : mul_full[dc_pkg::TOTAL_W-1:0];
        doubled   = prod_reg[dc_pkg::TOTAL_W-1] ? dc_pkg::TOTAL_MAX
                                                : {prod_reg[dc_pkg::TOTAL_W-2:0], 1'b0};
        if (n_reg == '0)
        begin
            total_next = '0;
        end
        else if (n_reg > W'(1))
        begin
            // leftover above one is a single prime
            total_next = doubled;
        end
        else
        begin
            total_next = prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= value_ext[W-1:0];
            p_reg    <= W'(dc_pkg::FIRST_PRIME);
            exp_reg  <= '0;
            prod_reg <= dc_pkg::TOTAL_W'(1);
        end
        else if (cmd.take_quotient)
        begin
            n_reg   <= quotient;
            exp_reg <= exp_reg + 1'b1;
        end
        else if (cmd.next_prime)
        begin
            prod_reg <= prod_next;
            exp_reg  <= '0;
            p_reg    <= (p_reg == W'(dc_pkg::FIRST_PRIME)) ? p_reg + W'(1) : p_reg + W'(2);
        end
        if (cmd.finish)
        begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_comb
    begin
        status.n_zero   = (n_reg == '0);
        status.div_busy = div_busy;
        status.rem_zero = (remainder == '0);
        status.exp_zero = (exp_reg == '0);
        status.n_gt1    = (n_reg > W'(1));
        status.p_le_q   = (p_reg <= quotient);
    end

    assign divisor_total = total_reg;
    assign done          = done_reg;

endmodule

[rtl/dc_ctrl.sv]
// sequencer for the trial division loop
module dc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dc_pkg::dc_status_t status,
    output dc_pkg::dc_cmd_t    cmd,
    output logic               busy
);

    dc_pkg::dc_state_t state_reg;
    dc_pkg::dc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dc_pkg::ST_LAUNCH;
                end
            end
            dc_pkg::ST_LAUNCH:
            begin
                state_next = status.n_zero ? dc_pkg::ST_FINISH : dc_pkg::ST_DIV;
            end
            dc_pkg::ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = dc_pkg::ST_DECIDE;
                end
            end
            dc_pkg::ST_DECIDE:
            begin
                // fresh divisor: stop once n is at most one or p exceeds n / p
                if (status.exp_zero && !(status.n_gt1 && status.p_le_q))
                begin
                    state_next = dc_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = dc_pkg::ST_LAUNCH;
                end
            end
            dc_pkg::ST_FINISH:
            begin
                state_next = dc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            dc_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            dc_pkg::ST_LAUNCH:
            begin
                cmd.div_start = !status.n_zero;
            end
            dc_pkg::ST_DIV:
            begin
                cmd = '0;
            end
            dc_pkg::ST_DECIDE:
            begin
                if (!(status.exp_zero && !(status.n_gt1 && status.p_le_q)))
                begin
                    cmd.take_quotient = status.rem_zero;
                    cmd.next_prime    = !status.rem_zero;
                end
            end
            dc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/divisor_count.sv]
// Counts the positive divisors of value_in by trial division (2, then odd numbers),
// dividing each factor out and multiplying (exponent + 1) into a product that
// saturates at 2047; an input of zero gives 0. A beat is taken when start is high
// and busy is low; the answer is held on divisor_total, with done high for one cycle
// when it appears, and the receiver cannot stall it. Every trial step is one division
// through a single bit-serial divider, and a new value is taken only once busy is low.
module divisor_count #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dc_pkg::VALUE_IN_W-1:0] value_in,
    output logic                          busy,
    output logic                          done,
    output logic [dc_pkg::TOTAL_W-1:0]    divisor_total
);

    dc_pkg::dc_cmd_t    cmd;
    dc_pkg::dc_status_t status;

    dc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dc_datapath #(
        .W (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .value_in      (value_in),
        .cmd           (cmd),
        .status        (status),
        .divisor_total (divisor_total),
        .done          (done)
    );

endmodule

[rtl/dc_checker.sv]
// port-level checks on the divisor count block, bound to the top level
`include "divisor_count_macros.svh"

module dc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted beat keeps the block busy
    `DC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // a result only shows once the block is free again
    `DC_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // every finished item gives a result
    `DC_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done)
    // the strobe lasts one cycle
    `DC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)

endmodule

bind divisor_count dc_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
